[hw/rtl/mp2_pkg.sv]
// Shared types and constants for the streaming 2-D max pooling block.
`default_nettype none

package mp2_pkg;

	localparam int SAMPLE_W     = 16;
	localparam int POOLED_W     = 15;
	localparam int POOL_REG_W   = 4;
	localparam int DIM_REG_W    = 11;
	localparam int CFG_INDEX_W  = 2;
	localparam int HEIGHT_LIMIT = 1024;
	localparam int ROW_W        = 10;
	localparam int HEIGHT_W     = 11;
	localparam int FIFO_DEPTH   = 4;

	// Register indexes on the configuration port.
	localparam logic [CFG_INDEX_W-1:0] CFG_POOL_SIZE    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd2;

	// Lanes of the position divider.
	localparam int LANES       = 4;
	localparam int LANE_COL    = 0;
	localparam int LANE_ROW    = 1;
	localparam int LANE_WIDTH  = 2;
	localparam int LANE_HEIGHT = 3;

	typedef enum logic [1:0] {
		FE_START,
		FE_DIVIDE,
		FE_RUN
	} fe_state_t;

	// Position of a sample inside its pooling window.
	typedef struct packed {
		logic first_col;
		logic last_col;
		logic first_row;
		logic last_row;
		logic last_plane;
	} win_flags_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

`default_nettype wire

[hw/rtl/mp2_div.sv]
// Four-lane restoring divider that rebuilds window positions after a register change.
`default_nettype none

module mp2_div #(
	parameter int DW = 11,
	parameter int PW = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [PW-1:0]                       divisor,
	input  logic [mp2_pkg::LANES-1:0][DW-1:0]   dividend,
	output logic                                done,
	output logic [mp2_pkg::LANES-1:0][DW-1:0]   quotient,
	output logic [mp2_pkg::LANES-1:0][PW-1:0]   remainder
);
	import mp2_pkg::*;

	localparam int CNT_W = $clog2(DW + 1);

	logic [LANES-1:0][DW-1:0] dvd_q;
	logic [LANES-1:0][PW-1:0] rem_q;
	logic [LANES-1:0][PW-1:0] rem_d;
	logic [LANES-1:0][PW:0]   trial;
	logic [LANES-1:0]         ge;
	logic [CNT_W-1:0]         count_q;
	logic                     busy_q;
	logic                     done_q;

	// One quotient bit per lane and cycle while busy; the quotient shifts into the dividend register.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			trial[l] = {rem_q[l], dvd_q[l][DW-1]};
			ge[l]    = trial[l] >= {1'b0, divisor};
			rem_d[l] = ge[l] ? PW'(trial[l] - {1'b0, divisor}) : PW'(trial[l]);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			for (int l = 0; l < LANES; l++) begin
				dvd_q[l] <= {dvd_q[l][DW-2:0], ge[l]};
				rem_q[l] <= rem_d[l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else if (start) begin
			count_q <= CNT_W'(DW);
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
		end else if (busy_q) begin
			count_q <= count_q - CNT_W'(1);
			if (count_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

[hw/rtl/mp2_front.sv]
// Front end: configuration registers, plane position counters and window classification.
`default_nettype none

module mp2_front #(
	parameter int MAX_WIDTH     = 1024,
	parameter int MAX_POOL_SIZE = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [mp2_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [mp2_pkg::DIM_REG_W-1:0]        cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [mp2_pkg::SAMPLE_W-1:0]  sample,
	input  logic                                 q_full,
	output logic                                 q_push,
	output logic signed [mp2_pkg::SAMPLE_W-1:0]  q_sample,
	output logic [$clog2(MAX_WIDTH)-1:0]         q_col,
	output mp2_pkg::win_flags_t                  q_flags
);
	import mp2_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = CW + 1;
	localparam int PW = $clog2(MAX_POOL_SIZE + 1);
	localparam int DW = (WW > HEIGHT_W) ? WW : HEIGHT_W;

	logic [POOL_REG_W-1:0] pool_size_q;
	logic [DIM_REG_W-1:0]  height_q;
	logic [DIM_REG_W-1:0]  width_q;

	logic [PW-1:0]       p_eff;
	logic [PW-1:0]       p_m1;
	logic [HEIGHT_W-1:0] h_eff;
	logic [WW-1:0]       w_eff;

	fe_state_t state_q;
	fe_state_t state_d;

	logic [CW-1:0]       col_q;
	logic [ROW_W-1:0]    row_q;
	logic [PW-1:0]       ciw_q;
	logic [PW-1:0]       riw_q;
	logic [CW-1:0]       oc_q;
	logic [ROW_W-1:0]    rb_q;
	logic [WW-1:0]       ncols_q;
	logic [HEIGHT_W-1:0] nrows_q;

	logic                     div_start;
	logic                     div_done;
	logic [LANES-1:0][DW-1:0] div_dvd;
	logic [LANES-1:0][DW-1:0] div_quo;
	logic [LANES-1:0][PW-1:0] div_rem;

	logic accept;
	logic in_region;
	logic col_end;
	logic row_end;
	logic col_wrap;
	logic row_wrap;

	// A write to an index with no register behind it changes nothing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q <= POOL_REG_W'(2);
			height_q    <= DIM_REG_W'(1024);
			width_q     <= DIM_REG_W'(1024);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_POOL_SIZE: begin
					pool_size_q <= cfg_data[POOL_REG_W-1:0];
				end
				CFG_IMAGE_HEIGHT: begin
					height_q <= cfg_data;
				end
				CFG_IMAGE_WIDTH: begin
					width_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// Out-of-range register values are pulled into the supported range.
	always_comb begin
		if (pool_size_q == '0) begin
			p_eff = PW'(1);
		end else if (int'(pool_size_q) > MAX_POOL_SIZE) begin
			p_eff = PW'(MAX_POOL_SIZE);
		end else begin
			p_eff = PW'(pool_size_q);
		end
		if (height_q == '0) begin
			h_eff = HEIGHT_W'(1);
		end else if (int'(height_q) > HEIGHT_LIMIT) begin
			h_eff = HEIGHT_W'(HEIGHT_LIMIT);
		end else begin
			h_eff = HEIGHT_W'(height_q);
		end
		if (width_q == '0) begin
			w_eff = WW'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
	end

	assign p_m1 = p_eff - PW'(1);

	always_comb begin
		div_dvd[LANE_COL]    = DW'(col_q);
		div_dvd[LANE_ROW]    = DW'(row_q);
		div_dvd[LANE_WIDTH]  = DW'(w_eff);
		div_dvd[LANE_HEIGHT] = DW'(h_eff);
	end

	mp2_div #(
		.DW(DW),
		.PW(PW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.divisor   (p_eff),
		.dividend  (div_dvd),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FE_START;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		unique case (state_q)
			FE_START: begin
				if (!cfg_we) begin
					div_start = 1'b1;
					state_d   = FE_DIVIDE;
				end
			end
			FE_DIVIDE: begin
				if (cfg_we) begin
					state_d = FE_START;
				end else if (div_done) begin
					state_d = FE_RUN;
				end
			end
			FE_RUN: begin
				if (cfg_we) begin
					state_d = FE_START;
				end
			end
			default: begin
				state_d = FE_START;
			end
		endcase
	end

	assign in_stall = (state_q != FE_RUN) || q_full || cfg_we;
	assign accept   = in_valid && !in_stall;

	assign in_region = (WW'(oc_q) < ncols_q) && (HEIGHT_W'(rb_q) < nrows_q);
	assign col_end   = ciw_q == p_m1;
	assign row_end   = riw_q == p_m1;
	assign col_wrap  = (WW'(col_q) + WW'(1)) >= w_eff;
	assign row_wrap  = (HEIGHT_W'(row_q) + HEIGHT_W'(1)) >= h_eff;

	// Samples outside the last full window never reach the back end.
	assign q_push   = accept && in_region;
	assign q_sample = sample;
	assign q_col    = oc_q;
	always_comb begin
		q_flags.first_col  = ciw_q == '0;
		q_flags.last_col   = col_end;
		q_flags.first_row  = riw_q == '0;
		q_flags.last_row   = row_end;
		q_flags.last_plane = col_end && row_end &&
			((HEIGHT_W'(rb_q) + HEIGHT_W'(1)) == nrows_q) &&
			((WW'(oc_q) + WW'(1)) == ncols_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			ciw_q   <= '0;
			riw_q   <= '0;
			oc_q    <= '0;
			rb_q    <= '0;
			ncols_q <= '0;
			nrows_q <= '0;
		end else if (state_q == FE_DIVIDE && div_done) begin
			ciw_q   <= div_rem[LANE_COL];
			oc_q    <= CW'(div_quo[LANE_COL]);
			riw_q   <= div_rem[LANE_ROW];
			rb_q    <= ROW_W'(div_quo[LANE_ROW]);
			ncols_q <= WW'(div_quo[LANE_WIDTH]);
			nrows_q <= HEIGHT_W'(div_quo[LANE_HEIGHT]);
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				ciw_q <= '0;
				oc_q  <= '0;
				if (row_wrap) begin
					row_q <= '0;
					riw_q <= '0;
					rb_q  <= '0;
				end else begin
					row_q <= row_q + ROW_W'(1);
					if (row_end) begin
						riw_q <= '0;
						rb_q  <= rb_q + ROW_W'(1);
					end else begin
						riw_q <= riw_q + PW'(1);
					end
				end
			end else begin
				col_q <= col_q + CW'(1);
				if (col_end) begin
					ciw_q <= '0;
					oc_q  <= oc_q + CW'(1);
				end else begin
					ciw_q <= ciw_q + PW'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/mp2_fifo.sv]
// Small register queue between the front end and the back end.
`default_nettype none

module mp2_fifo #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [WIDTH-1:0]    push_data,
	input  logic                pop,
	output logic [WIDTH-1:0]    pop_data,
	output mp2_pkg::fifo_stat_t stat
);
	import mp2_pkg::*;

	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full  = count_q == CNT_W'(DEPTH);
	assign stat.empty = count_q == '0;
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/mp2_back.sv]
// Back end: running row maximum, column line store and output register.
`default_nettype none

module mp2_back #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_valid,
	input  logic signed [mp2_pkg::SAMPLE_W-1:0]  q_sample,
	input  logic [$clog2(MAX_WIDTH)-1:0]         q_col,
	input  mp2_pkg::win_flags_t                  q_flags,
	output logic                                 q_pop,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [mp2_pkg::POOLED_W-1:0]         pooled_value,
	output logic                                 last_in_plane
);
	import mp2_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	logic [POOLED_W-1:0] line_mem [MAX_WIDTH];

	logic                       valid_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic [CW-1:0]              col_s1;
	win_flags_t                 flags_s1;
	logic [POOLED_W-1:0]        mem_rd_s1;
	logic                       byp_s1;
	logic [POOLED_W-1:0]        byp_data_s1;

	logic [POOLED_W-1:0] rm_q;
	logic                out_valid_q;
	logic [POOLED_W-1:0] pooled_q;
	logic                last_q;

	logic [POOLED_W-1:0] pos;
	logic [POOLED_W-1:0] rm_new;
	logic [POOLED_W-1:0] line_val;
	logic [POOLED_W-1:0] store_val;
	logic                emit;
	logic                out_free;
	logic                adv;
	logic                wr_en;

	// Negative samples clip to zero; the running maximum restarts at each window's first column.
	assign pos      = sample_s1[SAMPLE_W-1] ? '0 : sample_s1[POOLED_W-1:0];
	assign rm_new   = (flags_s1.first_col || pos > rm_q) ? pos : rm_q;
	assign line_val = byp_s1 ? byp_data_s1 : mem_rd_s1;
	assign store_val = (flags_s1.first_row || rm_new > line_val) ? rm_new : line_val;

	assign emit     = flags_s1.last_col && flags_s1.last_row;
	assign out_free = !out_valid_q || !out_stall;
	assign adv      = valid_s1 && (!emit || out_free);
	assign q_pop    = q_valid && (!valid_s1 || adv);
	assign wr_en    = adv && flags_s1.last_col;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_mem[col_s1] <= store_val;
		end
		if (q_pop) begin
			mem_rd_s1 <= line_mem[q_col];
		end
	end

	// A write to the column being read in the same cycle is forwarded.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			sample_s1   <= q_sample;
			col_s1      <= q_col;
			flags_s1    <= q_flags;
			byp_s1      <= wr_en && (col_s1 == q_col);
			byp_data_s1 <= store_val;
		end
		if (adv && emit) begin
			pooled_q <= store_val;
			last_q   <= flags_s1.last_plane;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rm_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				rm_q <= rm_new;
			end
			if (adv && emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign pooled_value  = pooled_q;
	assign last_in_plane = last_q;

endmodule

`default_nettype wire

[hw/rtl/max_pool_2d_stream.sv]
// Top level of the streaming non-overlapping 2-D max pooling block.
//
//   channel   direction  handshake            payload
//   config    in         cfg_we               cfg_index, cfg_data
//   input     in         in_valid / in_stall  sample (signed Q8.8)
//   output    out        out_valid/out_stall  pooled_value (UQ7.8, >= 0), last_in_plane
//
// One sample is taken per cycle while in_stall is low; after its last sample is accepted, a
// result passes the queue write at the accepting edge, then the line store read, then the
// result register, which drives the output.
// After reset and after every register write, a bit-serial divider rebuilds the window
// position from the plane counters; the input stalls until the divider is done.
// The line store needs no clearing pass: the first row of each window band writes it.
// Output stall backs up through the back end into the queue, then stalls the input.
`default_nettype none

module max_pool_2d_stream #(
	parameter int MAX_WIDTH     = 1024,
	parameter int MAX_POOL_SIZE = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [mp2_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [mp2_pkg::DIM_REG_W-1:0]        cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [mp2_pkg::SAMPLE_W-1:0]  sample,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [mp2_pkg::POOLED_W-1:0]         pooled_value,
	output logic                                 last_in_plane
);
	import mp2_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int QW = SAMPLE_W + CW + $bits(win_flags_t);

	// Words moving from the front end into the queue.
	logic                       q_push;
	logic signed [SAMPLE_W-1:0] fe_sample;
	logic [CW-1:0]              fe_col;
	win_flags_t                 fe_flags;

	// Words leaving the queue for the back end.
	logic                       q_pop;
	logic [QW-1:0]              q_head;
	fifo_stat_t                 fifo_stat;
	logic signed [SAMPLE_W-1:0] be_sample;
	logic [CW-1:0]              be_col;
	win_flags_t                 be_flags;

	// The front end classifies each sample by its place in the window and drops
	// those that lie past the last full window row or column.
	mp2_front #(
		.MAX_WIDTH     (MAX_WIDTH),
		.MAX_POOL_SIZE (MAX_POOL_SIZE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.q_full    (fifo_stat.full),
		.q_push    (q_push),
		.q_sample  (fe_sample),
		.q_col     (fe_col),
		.q_flags   (fe_flags)
	);

	mp2_fifo #(
		.WIDTH (QW),
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({fe_flags, fe_col, fe_sample}),
		.pop       (q_pop),
		.pop_data  (q_head),
		.stat      (fifo_stat)
	);

	assign be_sample = q_head[SAMPLE_W-1:0];
	assign be_col    = q_head[SAMPLE_W +: CW];
	assign be_flags  = q_head[QW-1 -: $bits(win_flags_t)];

	// The back end folds each row segment into a running maximum and merges it
	// with the column's partial maximum from earlier rows of the band.
	mp2_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (!fifo_stat.empty),
		.q_sample      (be_sample),
		.q_col         (be_col),
		.q_flags       (be_flags),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pooled_value  (pooled_value),
		.last_in_plane (last_in_plane)
	);

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !fifo_stat.full)
		else $error("queue written while full");

	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !fifo_stat.empty)
		else $error("queue read while empty");

	a_queue_level: assert property (@(posedge clk) disable iff (!arst_n)
		!(fifo_stat.full && fifo_stat.empty))
		else $error("queue reports full and empty together");

	a_cfg_resync: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> in_stall)
		else $error("input taken before window position was rebuilt");

endmodule

`default_nettype wire
